// ===== sv/cpts_pkg.sv =====
// Shared types and constants for the counter-priority task scheduler.
// Holds the slot record, the command and state encodings and the table size.
// No dependencies.
package cpts_pkg;

  localparam int NUM_TASKS = 16;
  localparam int IDX_W     = $clog2(NUM_TASKS);
  localparam int FUNC_W    = 4;
  localparam int TID_W     = 4;
  localparam int PRIO_W    = 4;
  localparam int CHAN_W    = 32;
  localparam int CNT_W     = 5;
  localparam int DEPTH_W   = 4;
  localparam int STATUS_W  = 2;

  localparam logic [PRIO_W-1:0]   BOOT_PRIO = PRIO_W'(2);
  localparam logic [STATUS_W-1:0] ST_OK       = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_NO_TASK  = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_REJECTED = STATUS_W'(2);

  typedef enum logic [1:0] {
    TS_RUNNING,
    TS_RUNNABLE,
    TS_SLEEPING,
    TS_ZOMBIE
  } task_state_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE,
    FN_TICK,
    FN_YIELD,
    FN_SLEEP,
    FN_WAKEUP,
    FN_KILL,
    FN_EXIT,
    FN_REMOVE,
    FN_PREEMPT_UP,
    FN_PREEMPT_DN
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE,
    S_PICK,
    S_RECHG,
    S_DESCHED,
    S_RUN,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic               valid;
    task_state_t        state;
    logic [CNT_W-1:0]   counter;
    logic [PRIO_W-1:0]  prio;
    logic [CHAN_W-1:0]  channel;
    logic               killed;
    logic [DEPTH_W-1:0] depth;
  } slot_t;

  typedef struct packed {
    logic  en;
    slot_t data;
  } slot_wr_t;

  function automatic slot_t empty_slot();
    slot_t s;
    s.valid    = 1'b0;
    s.state    = TS_RUNNABLE;
    s.counter  = '0;
    s.prio     = '0;
    s.channel  = '0;
    s.killed   = 1'b0;
    s.depth    = '0;
    return s;
  endfunction

  function automatic slot_t boot_slot();
    slot_t s;
    s       = empty_slot();
    s.valid = 1'b1;
    s.state = TS_RUNNING;
    s.prio  = BOOT_PRIO;
    return s;
  endfunction

endpackage

// ===== sv/cpts_in_if.sv =====
// Command channel of the task scheduler: valid/ready plus one command.
// Depends on cpts_pkg for field widths.
interface cpts_in_if;
  logic                         valid;
  logic                         ready;
  logic [cpts_pkg::FUNC_W-1:0]  func;
  logic [cpts_pkg::TID_W-1:0]   task_id;
  logic [cpts_pkg::PRIO_W-1:0]  priority_req;
  logic [cpts_pkg::CHAN_W-1:0]  channel;

  modport source (output valid, func, task_id, priority_req, channel, input ready);
  modport sink   (input valid, func, task_id, priority_req, channel, output ready);
endinterface

// ===== sv/cpts_out_if.sv =====
// Result channel of the task scheduler: valid/ready plus one result.
// Depends on cpts_pkg for field widths.
interface cpts_out_if;
  logic                          valid;
  logic                          ready;
  logic [cpts_pkg::TID_W-1:0]    current_task;
  logic                          switched;
  logic                          idle;
  logic [cpts_pkg::STATUS_W-1:0] status;
  logic                          current_killed;

  modport source (output valid, current_task, switched, idle, status, current_killed,
                  input ready);
  modport sink   (input valid, current_task, switched, idle, status, current_killed,
                  output ready);
endinterface

// ===== sv/counter_priority_task_scheduler_core.sv =====
// Top level of the counter-priority task scheduler: command sequencer,
// one-slot-per-cycle scan unit and result register. Depends on cpts_pkg,
// cpts_in_if, cpts_out_if and cpts_slot_table.
//
//   Port group  Direction  Carries
//   in_if       sink       func, task_id, priority_req, channel
//   out_if      source     current_task, switched, idle, status, current_killed
//
// A command without a reschedule steps through execute and done. Wakeup adds a
// scan of every slot. A reschedule adds a pick scan and, if a runnable task is
// found, a recharge scan when its counters ran out, a deschedule on a switch and run.
// Each scan visits the slot table one slot per cycle.
// Reset is synchronous and restores the boot slot table. A stalled result
// is held; the next command is taken meanwhile but waits to deliver.
module counter_priority_task_scheduler_core (
  input logic       clk,
  input logic       rst_n,
  cpts_in_if.sink   in_if,
  cpts_out_if.source out_if
);
  import cpts_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [FUNC_W-1:0]   func_r,  func_nxt;
  logic [TID_W-1:0]    tid_r,   tid_nxt;
  logic [PRIO_W-1:0]   prio_r,  prio_nxt;
  logic [CHAN_W-1:0]   chan_r,  chan_nxt;
  logic [IDX_W-1:0]    cur_r,   cur_nxt;
  logic [IDX_W-1:0]    idx_r,   idx_nxt;
  logic [IDX_W-1:0]    pick_r,  pick_nxt;
  logic [CNT_W-1:0]    best_r,  best_nxt;
  logic                found_r, found_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                sw_r,    sw_nxt;
  logic                idle_r,  idle_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [TID_W-1:0]    out_task_r,  out_task_nxt;
  logic                out_sw_r,    out_sw_nxt;
  logic                out_idle_r,  out_idle_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_killed_r, out_killed_nxt;

  logic [IDX_W-1:0] addr;
  slot_t            rd;
  slot_wr_t         wr;

  func_t               fn;
  logic                in_xfer;
  logic                out_free;
  logic                tid_ok;
  logic                runnable;
  logic [CNT_W-1:0]    recharged;
  logic [CNT_W-1:0]    scan_cnt;
  logic                scan_take;
  logic                scan_last;
  logic                found_after;
  logic [CNT_W-1:0]    best_after;
  logic [IDX_W-1:0]    pick_after;

  slot_t               exec_data;
  logic                exec_we;
  logic [STATUS_W-1:0] exec_status;
  logic                exec_sched;

  cpts_slot_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .addr    (addr),
    .rd_data (rd),
    .wr      (wr)
  );

  assign in_if.ready           = (state_r == S_IDLE);
  assign in_xfer               = in_if.valid && in_if.ready;
  assign out_free              = !out_valid_r || out_if.ready;
  assign out_if.valid          = out_valid_r;
  assign out_if.current_task   = out_task_r;
  assign out_if.switched       = out_sw_r;
  assign out_if.idle           = out_idle_r;
  assign out_if.status         = out_status_r;
  assign out_if.current_killed = out_killed_r;

  assign fn     = func_t'(func_r);
  assign tid_ok = 32'(tid_r) < 32'(NUM_TASKS);

  // Slot table address for the current step.
  always_comb begin
    case (state_r)
      S_EXEC: begin
        if (fn == FN_CREATE || fn == FN_KILL || fn == FN_REMOVE) begin
          addr = IDX_W'(tid_r);
        end else begin
          addr = cur_r;
        end
      end
      S_WAKE, S_PICK, S_RECHG: addr = idx_r;
      S_RUN:                   addr = pick_r;
      default:                 addr = cur_r;
    endcase
  end

  // Shared scan unit: one slot per cycle, largest counter wins, lowest index on ties.
  always_comb begin
    runnable    = rd.valid && (rd.state == TS_RUNNING || rd.state == TS_RUNNABLE);
    recharged   = CNT_W'((rd.counter >> 1) + CNT_W'(rd.prio));
    scan_cnt    = (state_r == S_RECHG) ? recharged : rd.counter;
    scan_take   = runnable && (!found_r || scan_cnt > best_r);
    scan_last   = (idx_r == IDX_W'(NUM_TASKS - 1));
    found_after = found_r || runnable;
    best_after  = scan_take ? scan_cnt : best_r;
    pick_after  = scan_take ? idx_r : pick_r;
  end

  // Single-slot command step.
  always_comb begin
    exec_data   = rd;
    exec_we     = 1'b0;
    exec_status = ST_OK;
    exec_sched  = 1'b0;
    case (fn)
      FN_CREATE: begin
        if (!tid_ok) begin
          exec_status = ST_NO_TASK;
        end else if (rd.valid) begin
          exec_status = ST_REJECTED;
        end else begin
          exec_data          = empty_slot();
          exec_data.valid    = 1'b1;
          exec_data.counter  = CNT_W'(prio_r);
          exec_data.prio     = prio_r;
          exec_we            = 1'b1;
        end
      end
      FN_TICK: begin
        exec_data.counter = rd.counter - CNT_W'(rd.counter != '0);
        exec_we           = 1'b1;
        exec_sched        = (exec_data.counter == '0) && (rd.depth == '0);
      end
      FN_YIELD: begin
        exec_data.counter = '0;
        exec_we           = 1'b1;
        exec_sched        = 1'b1;
      end
      FN_SLEEP: begin
        if (rd.state == TS_RUNNING || rd.state == TS_RUNNABLE) begin
          exec_data.state   = TS_SLEEPING;
          exec_data.channel = chan_r;
          exec_we           = 1'b1;
        end
        exec_sched = 1'b1;
      end
      FN_KILL: begin
        if (!tid_ok || !rd.valid) begin
          exec_status = ST_NO_TASK;
        end else begin
          exec_data.killed = 1'b1;
          if (rd.state == TS_SLEEPING) begin
            exec_data.state   = TS_RUNNABLE;
            exec_data.channel = '0;
          end
          exec_we = 1'b1;
        end
      end
      FN_EXIT: begin
        if (cur_r == '0) begin
          exec_status = ST_REJECTED;
        end else begin
          exec_data.state   = TS_ZOMBIE;
          exec_data.counter = '0;
          exec_we           = 1'b1;
          exec_sched        = 1'b1;
        end
      end
      FN_REMOVE: begin
        if (!tid_ok || !rd.valid) begin
          exec_status = ST_NO_TASK;
        end else if (IDX_W'(tid_r) == cur_r) begin
          exec_status = ST_REJECTED;
        end else begin
          exec_data = empty_slot();
          exec_we   = 1'b1;
        end
      end
      FN_PREEMPT_UP: begin
        if (rd.depth != '1) begin
          exec_data.depth = rd.depth + DEPTH_W'(1);
          exec_we         = 1'b1;
        end
      end
      FN_PREEMPT_DN: begin
        if (rd.depth != '0) begin
          exec_data.depth = rd.depth - DEPTH_W'(1);
          exec_we         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (fn == FN_WAKEUP) begin
          state_nxt = S_WAKE;
        end else if (exec_sched) begin
          state_nxt = S_PICK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAKE: begin
        if (scan_last) state_nxt = S_DONE;
      end
      S_PICK: begin
        if (scan_last) begin
          if (!found_after) begin
            state_nxt = S_DONE;
          end else if (best_after == '0) begin
            state_nxt = S_RECHG;
          end else if (pick_after != cur_r) begin
            state_nxt = S_DESCHED;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RECHG: begin
        if (scan_last) state_nxt = (pick_after != cur_r) ? S_DESCHED : S_RUN;
      end
      S_DESCHED: state_nxt = S_RUN;
      S_RUN:     state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and table writes.
  always_comb begin
    func_nxt       = func_r;
    tid_nxt        = tid_r;
    prio_nxt       = prio_r;
    chan_nxt       = chan_r;
    cur_nxt        = cur_r;
    idx_nxt        = '0;
    pick_nxt       = pick_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    status_nxt     = status_r;
    sw_nxt         = sw_r;
    idle_nxt       = idle_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_task_nxt   = out_task_r;
    out_sw_nxt     = out_sw_r;
    out_idle_nxt   = out_idle_r;
    out_status_nxt = out_status_r;
    out_killed_nxt = out_killed_r;
    wr.en          = 1'b0;
    wr.data        = rd;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          func_nxt   = in_if.func;
          tid_nxt    = in_if.task_id;
          prio_nxt   = in_if.priority_req;
          chan_nxt   = in_if.channel;
          status_nxt = ST_OK;
          sw_nxt     = 1'b0;
          idle_nxt   = 1'b0;
        end
      end
      S_EXEC: begin
        wr.en      = exec_we;
        wr.data    = exec_data;
        status_nxt = exec_status;
        found_nxt  = 1'b0;
        best_nxt   = '0;
      end
      S_WAKE: begin
        idx_nxt = scan_last ? '0 : idx_r + IDX_W'(1);
        if (rd.valid && rd.state == TS_SLEEPING && rd.channel == chan_r) begin
          wr.en           = 1'b1;
          wr.data.state   = TS_RUNNABLE;
          wr.data.channel = '0;
        end
      end
      S_PICK, S_RECHG: begin
        idx_nxt   = scan_last ? '0 : idx_r + IDX_W'(1);
        found_nxt = found_after;
        best_nxt  = best_after;
        pick_nxt  = pick_after;
        if (state_r == S_RECHG && rd.valid) begin
          wr.en           = 1'b1;
          wr.data.counter = recharged;
        end
        if (state_r == S_PICK && scan_last) begin
          if (!found_after) begin
            idle_nxt = 1'b1;
          end else if (best_after == '0) begin
            // Every runnable counter ran out: recharge and pick again.
            found_nxt = 1'b0;
            best_nxt  = '0;
          end
        end
      end
      S_DESCHED: begin
        sw_nxt = 1'b1;
        if (rd.state == TS_RUNNING) begin
          wr.en         = 1'b1;
          wr.data.state = TS_RUNNABLE;
        end
      end
      S_RUN: begin
        wr.en         = 1'b1;
        wr.data.state = TS_RUNNING;
        cur_nxt       = pick_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_task_nxt   = TID_W'(cur_r);
          out_sw_nxt     = sw_r;
          out_idle_nxt   = idle_r;
          out_status_nxt = status_r;
          out_killed_nxt = rd.killed;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    tid_r        <= tid_nxt;
    prio_r       <= prio_nxt;
    chan_r       <= chan_nxt;
    pick_r       <= pick_nxt;
    best_r       <= best_nxt;
    status_r     <= status_nxt;
    sw_r         <= sw_nxt;
    idle_r       <= idle_nxt;
    out_task_r   <= out_task_nxt;
    out_sw_r     <= out_sw_nxt;
    out_idle_r   <= out_idle_nxt;
    out_status_r <= out_status_nxt;
    out_killed_r <= out_killed_nxt;
  end

endmodule

// ===== sv/cpts_slot_table.sv =====
// Task slot table: one record per slot in flip-flops, one address per cycle
// for a read-modify-write. Depends on cpts_pkg.
module cpts_slot_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cpts_pkg::IDX_W-1:0]   addr,
  output cpts_pkg::slot_t              rd_data,
  input  cpts_pkg::slot_wr_t           wr
);
  import cpts_pkg::*;

  slot_t slots_r [NUM_TASKS];

  assign rd_data = slots_r[addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // Slot 0 is the boot task and starts out running.
      for (int i = 0; i < NUM_TASKS; i++) begin
        slots_r[i] <= (i == 0) ? boot_slot() : empty_slot();
      end
    end else if (wr.en) begin
      slots_r[addr] <= wr.data;
    end
  end

endmodule

// ===== sv/cpts_checker.sv =====
// Port-level checks for the task scheduler, attached to the top level by bind.
// Depends on cpts_pkg and counter_priority_task_scheduler_core.
module cpts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_switched,
  input logic                          out_idle,
  input logic [cpts_pkg::STATUS_W-1:0] out_status
);
  import cpts_pkg::*;

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The sequencer is busy in the cycle after each command transfer.
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while previous one still executing");

  // An idle reschedule never changes the running task.
  a_idle_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_idle && out_switched))
    else $error("idle result reports a task switch");

  // A switch only comes from a command that was not refused.
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_status == ST_OK)
    else $error("task switch reported with error status");

endmodule

bind counter_priority_task_scheduler_core cpts_checker u_cpts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_switched (out_if.switched),
  .out_idle     (out_if.idle),
  .out_status   (out_if.status)
);

// ===== tb/tb.sv =====
// Self-checking testbench for counter_priority_task_scheduler_core.
// Sends directed, then random, scheduler commands and checks every result against a predictor.
// Depends on cpts_pkg, cpts_in_if, cpts_out_if and counter_priority_task_scheduler_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpts_pkg::*;

  localparam int NUM_RANDOM        = 1300;
  localparam int QUIET_TAIL        = 150;
  localparam int HOLD_AT           = 300;
  localparam int LONG_HOLD         = 250;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int FIRST_UNUSED_FUNC = 10;
  localparam int LAST_UNUSED_FUNC  = 2**FUNC_W - 1;
  localparam logic [CHAN_W-1:0] CHAN_ONES = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    logic [CHAN_W-1:0] chan;
  } sched_cmd_t;

  typedef struct packed {
    logic [TID_W-1:0]    cur;
    logic                switched;
    logic                idle;
    logic [STATUS_W-1:0] status;
    logic                killed;
  } sched_res_t;

  typedef struct packed {
    logic               valid;
    task_state_t        state;
    logic [CNT_W-1:0]   counter;
    logic [PRIO_W-1:0]  prio;
    logic [CHAN_W-1:0]  chan;
    logic               killed;
    logic [DEPTH_W-1:0] depth;
  } task_slot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cpts_in_if  cmd_ch ();
  cpts_out_if res_ch ();

  counter_priority_task_scheduler_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_ch),
    .out_if (res_ch)
  );

  always #5 clk = ~clk;

  // Predicted scheduler state, updated as each command transfer is seen.
  task_slot_t       task_tbl [NUM_TASKS];
  logic [IDX_W-1:0] run_idx;

  sched_cmd_t pending_cmds[$];
  sched_res_t expected_outcomes[$];
  sched_cmd_t on_wire;

  int total_cmds = 0;
  int sent_count = 0;
  int results_seen = 0;
  int mismatches = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int stall_cycles = 0;
  int n_switch = 0;
  int n_idle = 0;
  int n_status = 0;
  logic [CHAN_W-1:0] chan_pool [6];

  function automatic void vacate(int i);
    task_tbl[i].valid   = 1'b0;
    task_tbl[i].state   = TS_RUNNABLE;
    task_tbl[i].counter = '0;
    task_tbl[i].prio    = '0;
    task_tbl[i].chan    = '0;
    task_tbl[i].killed  = 1'b0;
    task_tbl[i].depth   = '0;
  endfunction

  function automatic bit can_run(int i);
    return task_tbl[i].valid &&
           (task_tbl[i].state == TS_RUNNING || task_tbl[i].state == TS_RUNNABLE);
  endfunction

  // Largest counter among runnable slots, lowest index on ties; -1 if none.
  function automatic int best_runnable(output logic [CNT_W-1:0] top);
    int pick = -1;
    top = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (can_run(i) && (pick < 0 || task_tbl[i].counter > top)) begin
        pick = i;
        top  = task_tbl[i].counter;
      end
    end
    return pick;
  endfunction

  function automatic bit reschedule(output bit sw);
    logic [CNT_W-1:0] top;
    int pick;
    sw = 1'b0;
    pick = best_runnable(top);
    if (pick < 0) return 1'b1;
    if (top == '0) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (task_tbl[i].valid)
          task_tbl[i].counter = CNT_W'((task_tbl[i].counter >> 1) + task_tbl[i].prio);
      end
      pick = best_runnable(top);
    end
    if (pick != int'(run_idx)) begin
      if (task_tbl[run_idx].state == TS_RUNNING) task_tbl[run_idx].state = TS_RUNNABLE;
      run_idx = IDX_W'(pick);
      sw = 1'b1;
    end
    task_tbl[pick].state = TS_RUNNING;
    return 1'b0;
  endfunction

  function automatic sched_res_t predict_outcome(sched_cmd_t c);
    sched_res_t r;
    logic [IDX_W-1:0] cur;
    bit resched;
    bit sw;
    bit idl;
    r = '0;
    cur = run_idx;
    resched = 1'b0;
    sw = 1'b0;
    idl = 1'b0;
    case (c.func)
      FN_CREATE: begin
        if (int'(c.tid) >= NUM_TASKS) r.status = ST_NO_TASK;
        else if (task_tbl[c.tid].valid) r.status = ST_REJECTED;
        else begin
          vacate(c.tid);
          task_tbl[c.tid].valid   = 1'b1;
          task_tbl[c.tid].counter = CNT_W'(c.prio);
          task_tbl[c.tid].prio    = c.prio;
        end
      end
      FN_TICK: begin
        if (task_tbl[cur].counter > 0) task_tbl[cur].counter--;
        resched = (task_tbl[cur].counter == 0 && task_tbl[cur].depth == 0);
      end
      FN_YIELD: begin
        task_tbl[cur].counter = '0;
        resched = 1'b1;
      end
      FN_SLEEP: begin
        if (task_tbl[cur].state == TS_RUNNING || task_tbl[cur].state == TS_RUNNABLE) begin
          task_tbl[cur].state = TS_SLEEPING;
          task_tbl[cur].chan  = c.chan;
        end
        resched = 1'b1;
      end
      FN_WAKEUP: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (task_tbl[i].valid && task_tbl[i].state == TS_SLEEPING &&
              task_tbl[i].chan == c.chan) begin
            task_tbl[i].state = TS_RUNNABLE;
            task_tbl[i].chan  = '0;
          end
        end
      end
      FN_KILL: begin
        if (int'(c.tid) >= NUM_TASKS || !task_tbl[c.tid].valid) r.status = ST_NO_TASK;
        else begin
          task_tbl[c.tid].killed = 1'b1;
          if (task_tbl[c.tid].state == TS_SLEEPING) begin
            task_tbl[c.tid].state = TS_RUNNABLE;
            task_tbl[c.tid].chan  = '0;
          end
        end
      end
      FN_EXIT: begin
        if (cur == 0) r.status = ST_REJECTED;
        else begin
          task_tbl[cur].state   = TS_ZOMBIE;
          task_tbl[cur].counter = '0;
          resched = 1'b1;
        end
      end
      FN_REMOVE: begin
        if (int'(c.tid) >= NUM_TASKS || !task_tbl[c.tid].valid) r.status = ST_NO_TASK;
        else if (c.tid == cur) r.status = ST_REJECTED;
        else vacate(c.tid);
      end
      FN_PREEMPT_UP: begin
        if (task_tbl[cur].depth != '1) task_tbl[cur].depth++;
      end
      FN_PREEMPT_DN: begin
        if (task_tbl[cur].depth != '0) task_tbl[cur].depth--;
      end
      default: ;
    endcase
    if (resched) idl = reschedule(sw);
    r.cur      = run_idx;
    r.switched = sw;
    r.idle     = idl;
    r.killed   = task_tbl[run_idx].killed;
    return r;
  endfunction

  function automatic void add_cmd(int func, int tid, int prio, logic [CHAN_W-1:0] chan);
    sched_cmd_t c;
    c.func = FUNC_W'(func);
    c.tid  = TID_W'(tid);
    c.prio = PRIO_W'(prio);
    c.chan = chan;
    pending_cmds.push_back(c);
  endfunction

  // Idling comes in phases: none, light and heavy, and stops near the end of the run.
  function automatic bit take_break(int done, int total);
    int level;
    if (done >= total - QUIET_TAIL) return 1'b0;
    level = (done / 128) % 3;
    if (level == 1) return $urandom_range(0, 7) == 0;
    if (level == 2) return $urandom_range(0, 2) == 0;
    return 1'b0;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Command driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_outcomes.push_back(predict_outcome(on_wire));
        sent_count <= sent_count + 1;
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          cmd_ch.valid <= 1'b0;
        end else if (take_break(sent_count, total_cmds)) begin
          send_gap <= $urandom_range(0, 13);
          cmd_ch.valid <= 1'b0;
        end else begin
          on_wire = pending_cmds.pop_front();
          cmd_ch.func         <= on_wire.func;
          cmd_ch.task_id      <= on_wire.tid;
          cmd_ch.priority_req <= on_wire.prio;
          cmd_ch.channel      <= on_wire.chan;
          cmd_ch.valid        <= 1'b1;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin : result_monitor
    sched_res_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      recv_gap <= 0;
      hold_left <= 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("current_task", want.cur, res_ch.current_task);
          check_field("switched", want.switched, res_ch.switched);
          check_field("idle", want.idle, res_ch.idle);
          check_field("status", want.status, res_ch.status);
          check_field("current_killed", want.killed, res_ch.current_killed);
        end
        results_seen <= results_seen + 1;
        n_switch <= n_switch + res_ch.switched;
        n_idle   <= n_idle + res_ch.idle;
        n_status <= n_status + (res_ch.status != ST_OK);
      end
      // One long hold-off lets the block fill up and stall its command input.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else if (!held_once && results_seen >= HOLD_AT) begin
        hold_left <= LONG_HOLD - 1;
        held_once <= 1'b1;
        res_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_ch.ready <= 1'b0;
      end else if (take_break(results_seen + 64, total_cmds)) begin
        recv_gap <= $urandom_range(0, 13);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d idle cycles, %0d results outstanding",
                 stall_cycles, expected_outcomes.size());
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    int n;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = '0;
    cmd_ch.task_id = '0;
    cmd_ch.priority_req = '0;
    cmd_ch.channel = '0;
    res_ch.ready = 1'b0;

    for (int i = 0; i < NUM_TASKS; i++) vacate(i);
    task_tbl[0].valid = 1'b1;
    task_tbl[0].state = TS_RUNNING;
    task_tbl[0].prio  = BOOT_PRIO;
    run_idx = '0;

    chan_pool[0] = '0;
    chan_pool[1] = CHAN_ONES;
    for (int i = 2; i < 6; i++) chan_pool[i] = $urandom;

    // Directed part: zero-priority pick, idle, wakeup, killed sleeper, rejections,
    // preemption around a tick, exit and removal edge cases, unused codes.
    add_cmd(FN_CREATE, 1, 0, '0);
    add_cmd(FN_SLEEP, 0, 0, '0);
    add_cmd(FN_SLEEP, 0, 0, CHAN_ONES);
    add_cmd(FN_WAKEUP, 0, 0, '0);
    add_cmd(FN_TICK, 0, 0, '0);
    add_cmd(FN_KILL, 1, 0, '0);
    add_cmd(FN_KILL, 5, 0, '0);
    add_cmd(FN_CREATE, 0, 15, '0);
    add_cmd(FN_CREATE, 15, 15, CHAN_ONES);
    add_cmd(FN_YIELD, 0, 0, '0);
    add_cmd(FN_PREEMPT_UP, 0, 0, '0);
    add_cmd(FN_TICK, 0, 0, '0);
    add_cmd(FN_PREEMPT_DN, 0, 0, '0);
    add_cmd(FN_EXIT, 0, 0, '0);
    add_cmd(FN_REMOVE, 15, 0, '0);
    add_cmd(FN_REMOVE, 0, 0, '0);
    add_cmd(FN_REMOVE, 9, 0, '0);
    add_cmd(FN_EXIT, 0, 0, '0);
    add_cmd(LAST_UNUSED_FUNC, 15, 15, CHAN_ONES);
    add_cmd(FIRST_UNUSED_FUNC, 0, 0, '0);
    add_cmd(FN_WAKEUP, 0, 0, CHAN_ONES);
    add_cmd(FN_KILL, 0, 0, '0);
    add_cmd(FN_TICK, 0, 0, '0);

    // Random part: a weighted command mix with channels mostly from a small pool so
    // that sleepers get woken, plus occasional preempt bursts that hit saturation.
    n = pending_cmds.size() + NUM_RANDOM;
    while (pending_cmds.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 14)
        add_cmd(FN_CREATE, $urandom_range(0, 15),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 15), $urandom);
      else if (r < 34) add_cmd(FN_TICK, $urandom_range(0, 15), 0, '0);
      else if (r < 42) add_cmd(FN_YIELD, 0, $urandom_range(0, 15), '0);
      else if (r < 60)
        add_cmd((r < 50) ? FN_SLEEP : FN_WAKEUP, $urandom_range(0, 15), 0,
                ($urandom_range(0, 4) == 0) ? $urandom : chan_pool[$urandom_range(0, 5)]);
      else if (r < 66) add_cmd(FN_KILL, $urandom_range(0, 15), 0, '0);
      else if (r < 72) add_cmd(FN_EXIT, 0, 0, $urandom);
      else if (r < 79) add_cmd(FN_REMOVE, $urandom_range(0, 15), 0, '0);
      else if (r < 87) add_cmd(FN_PREEMPT_UP, 0, 0, '0);
      else if (r < 95) add_cmd(FN_PREEMPT_DN, 0, 0, '0);
      else if (r < 98)
        add_cmd($urandom_range(FIRST_UNUSED_FUNC, LAST_UNUSED_FUNC), $urandom_range(0, 15),
                $urandom_range(0, 15), $urandom);
      else begin
        repeat (17) add_cmd(FN_PREEMPT_UP, 0, 0, '0);
        add_cmd(FN_TICK, 0, 0, '0);
        repeat (17) add_cmd(FN_PREEMPT_DN, 0, 0, '0);
      end
    end
    total_cmds = pending_cmds.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (sent_count < total_cmds || expected_outcomes.size() != 0);
    repeat (2 * NUM_TASKS + 20) @(posedge clk);
    @(negedge clk);

    $display("Covered %0d commands and %0d results: %0d task switches, %0d idle picks,",
             sent_count, results_seen, n_switch, n_idle);
    $display("%0d error statuses, and one %0d-cycle result stall with commands queued.",
             n_status, LONG_HOLD);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
